// ----- rtl/kct_pkg.sv -----
package kct_pkg;

  // Field widths fixed by the item format
  localparam int KEY_W = 9;
  localparam int TIME_W = 32;
  localparam int HOLD_W = 16;
  localparam int WIN_W = 16;

  // Default table size and the largest table the key field can address
  localparam int NUM_KEYS_DEF = 512;
  localparam int KEY_SPACE = 1 << KEY_W;

  // Register defaults
  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd250;

  // Queue depths
  localparam int OP_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_SWEEP = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Key action codes
  localparam logic [1:0] ACT_UP = 2'd0;
  localparam logic [1:0] ACT_DOWN = 2'd1;

  // Input word
  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key_id;
    logic [1:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic [HOLD_W-1:0] hold_ms;
  } kct_item_t;

  // Result word
  typedef struct packed {
    logic held;
    logic pressed;
    logic released;
    logic double_click;
    logic long_press;
  } kct_result_t;

  // Operation kinds after classification
  typedef enum logic [1:0] {
    OP_RECORD,
    OP_SWEEP,
    OP_QUERY,
    OP_NULL_QUERY
  } kct_kind_t;

  // Classified operation passed from front to back
  typedef struct packed {
    kct_kind_t         kind;
    logic [KEY_W-1:0]  key_id;
    logic [1:0]        action;
    logic [TIME_W-1:0] now_ms;
    logic [HOLD_W-1:0] hold_ms;
  } kct_op_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP_RD,
    ST_SWEEP_WR
  } kct_state_t;

endpackage

// ----- rtl/kct_fifo.sv -----
module kct_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = slots[rd_ptr];

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/kct_front.sv -----
module kct_front #(
  parameter int NUM_KEYS = kct_pkg::NUM_KEYS_DEF
) (
  input  logic              push,
  input  kct_pkg::kct_item_t item,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output kct_pkg::kct_op_t  q_data
);

  logic in_range;
  logic keep;

  assign in_range = (32'(item.key_id) < NUM_KEYS);

  // Classify the word; drop unused commands and records for absent keys
  always_comb begin
    keep = 1'b0;
    q_data.kind = kct_pkg::OP_NULL_QUERY;
    q_data.key_id = item.key_id;
    q_data.action = item.action;
    q_data.now_ms = item.now_ms;
    q_data.hold_ms = item.hold_ms;
    case (item.command)
      kct_pkg::CMD_RECORD: begin
        keep = in_range;
        q_data.kind = kct_pkg::OP_RECORD;
      end
      kct_pkg::CMD_SWEEP: begin
        keep = 1'b1;
        q_data.kind = kct_pkg::OP_SWEEP;
      end
      kct_pkg::CMD_QUERY: begin
        keep = 1'b1;
        q_data.kind = in_range ? kct_pkg::OP_QUERY : kct_pkg::OP_NULL_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full = q_full;
  assign q_push = push && !q_full && keep;

endmodule

// ----- rtl/kct_back.sv -----
module kct_back #(
  parameter int NUM_KEYS = kct_pkg::NUM_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kct_pkg::WIN_W-1:0]     window,
  input  logic                          q_empty,
  input  kct_pkg::kct_op_t              q_data,
  output logic                          q_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output kct_pkg::kct_result_t          res_data
);

  localparam int DEPTH = (NUM_KEYS < kct_pkg::KEY_SPACE) ? NUM_KEYS : kct_pkg::KEY_SPACE;
  localparam int AW = $clog2(DEPTH);

  typedef struct packed {
    logic       present;
    logic [1:0] last_action;
    logic       press_valid;
    logic       click_valid;
    logic       double_flag;
  } kct_stat_t;

  typedef struct packed {
    logic [kct_pkg::TIME_W-1:0] press_time;
    logic [kct_pkg::TIME_W-1:0] click_time;
  } kct_times_t;

  kct_stat_t  stat_mem [DEPTH];
  kct_times_t time_mem [DEPTH];

  kct_pkg::kct_state_t state;
  kct_pkg::kct_state_t state_next;
  logic [AW-1:0]       cnt;
  logic [AW-1:0]       cnt_next;
  kct_pkg::kct_op_t    cur;

  logic          stat_rd_en;
  logic [AW-1:0] stat_rd_addr;
  kct_stat_t     stat_rd;
  logic          stat_we;
  logic [AW-1:0] stat_wr_addr;
  kct_stat_t     stat_wdata;
  logic          time_rd_en;
  kct_times_t    time_rd;
  logic          time_we;
  kct_times_t    time_wdata;

  logic [AW-1:0]              cur_idx;
  logic                       last_idx;
  logic                       prev_up;
  logic                       new_press;
  logic [kct_pkg::TIME_W-1:0] click_gap;
  logic [kct_pkg::TIME_W-1:0] held_for;
  kct_pkg::kct_result_t       query_res;

  assign cur_idx = cur.key_id[AW-1:0];
  assign last_idx = (cnt == AW'(DEPTH-1));

  // Status table
  always_ff @(posedge clk) begin
    if (stat_rd_en) begin
      stat_rd <= stat_mem[stat_rd_addr];
    end
    if (stat_we) begin
      stat_mem[stat_wr_addr] <= stat_wdata;
    end
  end

  // Time table
  always_ff @(posedge clk) begin
    if (time_rd_en) begin
      time_rd <= time_mem[stat_rd_addr];
    end
    if (time_we) begin
      time_mem[cur_idx] <= time_wdata;
    end
  end

  // Record update: a down after an up starts a new press
  assign prev_up = !stat_rd.present || (stat_rd.last_action == kct_pkg::ACT_UP);
  assign new_press = (cur.action == kct_pkg::ACT_DOWN) && prev_up;
  assign click_gap = cur.now_ms - time_rd.click_time;
  assign held_for = cur.now_ms - time_rd.press_time;

  // Query status of the entry
  always_comb begin
    query_res = '0;
    if (cur.kind == kct_pkg::OP_QUERY) begin
      query_res.held = stat_rd.present;
      query_res.pressed = stat_rd.present && (stat_rd.last_action != kct_pkg::ACT_UP);
      query_res.released = stat_rd.present && (stat_rd.last_action == kct_pkg::ACT_UP);
      query_res.double_click = stat_rd.double_flag;
      query_res.long_press = query_res.pressed && stat_rd.press_valid &&
                             (held_for >= {16'b0, cur.hold_ms});
    end
  end

  assign res_data = query_res;

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kct_pkg::ST_CLEAR;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // Latch the operation being worked on
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Sequence clearing, read-modify-write and sweep
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    q_pop = 1'b0;
    res_push = 1'b0;
    stat_rd_en = 1'b0;
    stat_rd_addr = cnt;
    stat_we = 1'b0;
    stat_wr_addr = cnt;
    stat_wdata = stat_rd;
    time_rd_en = 1'b0;
    time_we = 1'b0;
    time_wdata.press_time = cur.now_ms;
    time_wdata.click_time = cur.now_ms;
    case (state)
      kct_pkg::ST_CLEAR: begin
        stat_we = 1'b1;
        stat_wdata = '0;
        cnt_next = cnt + 1'b1;
        if (last_idx) begin
          cnt_next = '0;
          state_next = kct_pkg::ST_IDLE;
        end
      end
      kct_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          stat_rd_en = 1'b1;
          time_rd_en = 1'b1;
          stat_rd_addr = q_data.key_id[AW-1:0];
          cnt_next = '0;
          state_next = (q_data.kind == kct_pkg::OP_SWEEP) ? kct_pkg::ST_SWEEP_RD
                                                          : kct_pkg::ST_EXEC;
        end
      end
      kct_pkg::ST_EXEC: begin
        case (cur.kind)
          kct_pkg::OP_RECORD: begin
            stat_we = 1'b1;
            stat_wr_addr = cur_idx;
            stat_wdata.present = 1'b1;
            stat_wdata.last_action = cur.action;
            if (new_press) begin
              time_we = 1'b1;
              stat_wdata.press_valid = 1'b1;
              stat_wdata.click_valid = 1'b1;
              stat_wdata.double_flag = stat_rd.click_valid &&
                                       (click_gap <= {16'b0, window});
            end else if (cur.action == kct_pkg::ACT_UP) begin
              stat_wdata.press_valid = 1'b0;
            end
            state_next = kct_pkg::ST_IDLE;
          end
          kct_pkg::OP_QUERY, kct_pkg::OP_NULL_QUERY: begin
            if (!res_full) begin
              res_push = 1'b1;
              state_next = kct_pkg::ST_IDLE;
            end
          end
          default: begin
            state_next = kct_pkg::ST_IDLE;
          end
        endcase
      end
      kct_pkg::ST_SWEEP_RD: begin
        stat_rd_en = 1'b1;
        state_next = kct_pkg::ST_SWEEP_WR;
      end
      kct_pkg::ST_SWEEP_WR: begin
        stat_we = 1'b1;
        stat_wdata.double_flag = 1'b0;
        if (stat_rd.last_action == kct_pkg::ACT_UP) begin
          stat_wdata.present = 1'b0;
        end
        if (last_idx) begin
          cnt_next = '0;
          state_next = kct_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
          state_next = kct_pkg::ST_SWEEP_RD;
        end
      end
      default: begin
        state_next = kct_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // No work is taken while the table is being cleared or swept
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state == kct_pkg::ST_CLEAR || state == kct_pkg::ST_SWEEP_RD ||
     state == kct_pkg::ST_SWEEP_WR) |-> !q_pop)
    else $error("operation taken while table busy");

  // A taken operation is carried out in the following cycle
  a_pop_then_work: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == kct_pkg::ST_EXEC || state == kct_pkg::ST_SWEEP_RD))
    else $error("popped operation not started");

  // Only queries produce results
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (state == kct_pkg::ST_EXEC &&
                  (cur.kind == kct_pkg::OP_QUERY || cur.kind == kct_pkg::OP_NULL_QUERY)))
    else $error("result from a non-query");

  // A sweep ends exactly at the last entry
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == kct_pkg::ST_SWEEP_WR && last_idx) |=> state == kct_pkg::ST_IDLE)
    else $error("sweep did not finish at last entry");
`endif

endmodule

// ----- rtl/key_state_click_tracker_core.sv -----
// Per-key click tracker. Words enter through a queue-style port (push/full) and
// results leave through another (empty/pop); only a query yields a result word.
// A front end classifies each word into a two-entry operation queue, and a back
// end runs it against a one-entry-per-key status table and time table, each a
// single-port-read, single-port-write memory. A record or query passes through
// the back end as a memory read, then an update or compare; a query waits in
// the compare step while the result queue is full. A frame sweep walks every
// entry with a read and then a write for each. After reset the back end runs a
// clearing pass over every entry before it takes the first word; words may queue
// in the meantime. The double-click window register sits at addresses 0 to 3.
module key_state_click_tracker_core #(
  parameter int NUM_KEYS = kct_pkg::NUM_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  kct_pkg::kct_item_t   item,
  output logic                 full,
  output logic                 empty,
  input  logic                 pop,
  output kct_pkg::kct_result_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [kct_pkg::WIN_W-1:0] window;
  logic                      cfg_wr;

  logic                 op_push;
  logic                 op_full;
  logic                 op_empty;
  logic                 op_pop;
  kct_pkg::kct_op_t     op_in;
  kct_pkg::kct_op_t     op_out;
  logic                 res_push;
  logic                 res_full;
  kct_pkg::kct_result_t res_in;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, window};

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= kct_pkg::WINDOW_RESET;
    end else if (cfg_wr) begin
      window <= pwdata[kct_pkg::WIN_W-1:0];
    end
  end

  kct_front #(
    .NUM_KEYS(NUM_KEYS)
  ) u_front (
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (op_full),
    .q_push (op_push),
    .q_data (op_in)
  );

  kct_fifo #(
    .W     ($bits(kct_pkg::kct_op_t)),
    .DEPTH (kct_pkg::OP_Q_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_out),
    .empty (op_empty)
  );

  kct_back #(
    .NUM_KEYS(NUM_KEYS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .window   (window),
    .q_empty  (op_empty),
    .q_data   (op_out),
    .q_pop    (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_in)
  );

  kct_fifo #(
    .W     ($bits(kct_pkg::kct_result_t)),
    .DEPTH (kct_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
